### src/imu_frame_deframer_top_defines.svh
// Assertion macros for the IMU frame deframer.
// Bodies are empty when SYNTHESIS is defined.
`ifndef IMU_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define IMU_FRAME_DEFRAMER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked check, masked while reset is asserted
`define IFD_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset
`define IFD_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IFD_ASSERT(label, clk, rst_n, prop, msg)
`define IFD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### src/ifd_pkg.sv
`timescale 1ns / 1ps

package ifd_pkg;

    // Frame layout
    localparam int PAYLOAD_BYTES = 28;
    localparam int WORD_BYTES    = 24;
    localparam int NUM_WORDS     = 6;
    localparam int HDR_BYTES     = 3;
    localparam int CNT_W         = 5;
    localparam int STORE_IDX_W   = $clog2(WORD_BYTES);

    // Sync and header bytes
    localparam logic [7:0] SYNC_BYTE = 8'h24;
    localparam logic [7:0] HDR_BYTE0 = 8'h41;
    localparam logic [7:0] HDR_BYTE1 = 8'h44;
    localparam logic [7:0] HDR_BYTE2 = 8'h49;

    localparam logic [31:0] WORD_MIN = 32'h8000_0000;
    localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    typedef logic [WORD_BYTES-1:0][7:0] store_t;

    // One decoded frame, already negated
    typedef struct packed {
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
        logic signed [31:0] rate_x;
        logic signed [31:0] rate_y;
        logic signed [31:0] rate_z;
    } frame_t;

    // Expected header byte at position idx (positions past the end reuse the last)
    function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = HDR_BYTE0;
            2'd1:    b = HDR_BYTE1;
            default: b = HDR_BYTE2;
        endcase
        return b;
    endfunction

    // Negate, saturating the most negative word to the largest positive one
    function automatic logic signed [31:0] neg_sat(input logic [31:0] raw);
        logic [31:0] r;
        if (raw == WORD_MIN)
        begin
            r = WORD_MAX;
        end
        else
        begin
            r = 32'd0 - raw;
        end
        return $signed(r);
    endfunction

    // Little-endian word k of the store
    function automatic logic [31:0] word_at(input store_t s, input int k);
        return {s[4*k+3], s[4*k+2], s[4*k+1], s[4*k]};
    endfunction

    function automatic frame_t build_frame(input store_t s);
        frame_t f;
        f.accel_x = neg_sat(word_at(s, 0));
        f.accel_y = neg_sat(word_at(s, 1));
        f.accel_z = neg_sat(word_at(s, 2));
        f.rate_x  = neg_sat(word_at(s, 3));
        f.rate_y  = neg_sat(word_at(s, 4));
        f.rate_z  = neg_sat(word_at(s, 5));
        return f;
    endfunction

endpackage

### src/ifd_core.sv
`timescale 1ns / 1ps

// Frame state machine and payload store. Works on one byte per accepted word;
// frame_done and frame are valid in the cycle the last payload byte arrives.
module ifd_core
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           byte_fire,
    input  logic [7:0]     rx_byte,
    output logic           frame_done,
    output ifd_pkg::frame_t frame
);

    ifd_pkg::phase_t               phase_reg, phase_next;
    logic [ifd_pkg::CNT_W-1:0]     count_reg, count_next;
    logic                          match_reg, match_next;
    ifd_pkg::store_t               store_reg, store_next;

    logic [ifd_pkg::CNT_W-1:0]     count_inc;
    logic [1:0]                    hdr_idx;
    logic                          hdr_ok;
    logic                          last_byte;
    logic                          store_we;

    // Shared decode
    assign count_inc = count_reg + 1'b1;
    assign hdr_idx   = (count_reg > ifd_pkg::CNT_W'(2)) ? 2'd2 : count_reg[1:0];
    assign hdr_ok    = match_reg && (rx_byte == ifd_pkg::hdr_byte(hdr_idx));
    assign last_byte = (count_inc >= ifd_pkg::CNT_W'(ifd_pkg::PAYLOAD_BYTES));

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        match_next = match_reg;
        if (byte_fire)
        begin
            case (phase_reg)
                ifd_pkg::PH_HEADER:
                begin
                    match_next = hdr_ok;
                    count_next = count_inc;
                    if (count_inc >= ifd_pkg::CNT_W'(ifd_pkg::HDR_BYTES))
                    begin
                        phase_next = hdr_ok ? ifd_pkg::PH_PAYLOAD : ifd_pkg::PH_HUNT;
                        count_next = '0;
                        match_next = 1'b1;
                    end
                end
                ifd_pkg::PH_PAYLOAD:
                begin
                    count_next = count_inc;
                    if (last_byte)
                    begin
                        phase_next = ifd_pkg::PH_HUNT;
                        count_next = '0;
                        match_next = 1'b1;
                    end
                end
                default:
                begin
                    // hunt; the unused code behaves the same
                    if (rx_byte == ifd_pkg::SYNC_BYTE)
                    begin
                        phase_next = ifd_pkg::PH_HEADER;
                        count_next = '0;
                        match_next = 1'b1;
                    end
                    else
                    begin
                        phase_next = ifd_pkg::PH_HUNT;
                    end
                end
            endcase
        end
    end

    // Outputs
    always_comb
    begin
        store_we   = 1'b0;
        frame_done = 1'b0;
        case (phase_reg)
            ifd_pkg::PH_PAYLOAD:
            begin
                store_we   = byte_fire &&
                             (count_reg < ifd_pkg::CNT_W'(ifd_pkg::WORD_BYTES));
                frame_done = byte_fire && last_byte;
            end
            default:
            begin
                store_we   = 1'b0;
                frame_done = 1'b0;
            end
        endcase
    end

    // Store with the current byte merged in, so a word byte arriving last is seen
    always_comb
    begin
        store_next = store_reg;
        if (store_we)
        begin
            store_next[count_reg[ifd_pkg::STORE_IDX_W-1:0]] = rx_byte;
        end
    end

    assign frame = ifd_pkg::build_frame(store_next);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ifd_pkg::PH_HUNT;
            count_reg <= '0;
            match_reg <= 1'b1;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            match_reg <= match_next;
        end
    end

    // Payload bytes, no reset
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg <= store_next;
        end
    end

endmodule

### src/imu_frame_deframer_top.sv
`timescale 1ns / 1ps
// IMU frame deframer.
// Input channel: one received serial byte per word on rx_byte, with
// in_valid / in_ready. The block hunts for the sync byte 0x24, checks the
// three header bytes that follow, then collects a 28-byte payload.
// Output channel: one word per complete frame on out_valid / out_ready,
// carrying six negated signed 32-bit fields (accel x,y,z and rate x,y,z);
// the most negative raw value saturates to the largest positive one.
// The frame word is registered and appears in the cycle after the last
// payload byte is accepted. Throughput: one input byte per cycle while
// in_ready is high, set by the single state register update per byte.
// Reset (rst_n low, asynchronous) returns the block to hunt and empties
// the output register. If the receiver stalls while a frame word is held,
// in_ready drops until that word is taken, so no frame is lost; with the
// output register free, bytes keep flowing every cycle.
`include "imu_frame_deframer_top_defines.svh"

module imu_frame_deframer_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] accel_x,
    output logic signed [31:0] accel_y,
    output logic signed [31:0] accel_z,
    output logic signed [31:0] rate_x,
    output logic signed [31:0] rate_y,
    output logic signed [31:0] rate_z
);

    logic            byte_fire;
    logic            frame_done;
    ifd_pkg::frame_t frame;
    ifd_pkg::frame_t frame_reg, frame_next;
    logic            out_valid_reg, out_valid_next;

    // Accept while the output register is free or being drained
    assign in_ready  = !out_valid_reg || out_ready;
    assign byte_fire = in_valid && in_ready;

    ifd_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_fire  (byte_fire),
        .rx_byte    (rx_byte),
        .frame_done (frame_done),
        .frame      (frame)
    );

    // Output register next value
    always_comb
    begin
        out_valid_next = out_valid_reg;
        frame_next     = frame_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (frame_done)
        begin
            out_valid_next = 1'b1;
            frame_next     = frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    assign out_valid = out_valid_reg;
    assign accel_x   = frame_reg.accel_x;
    assign accel_y   = frame_reg.accel_y;
    assign accel_z   = frame_reg.accel_z;
    assign rate_x    = frame_reg.rate_x;
    assign rate_y    = frame_reg.rate_y;
    assign rate_z    = frame_reg.rate_z;

    // Checks
    `IFD_ASSERT(a_stall_only_when_full, clk, rst_n, !in_ready |-> out_valid_reg, "in_ready low with empty output register")
    `IFD_ASSERT(a_done_loads_output, clk, rst_n, frame_done |=> out_valid_reg, "completed frame not held in output register")
    `IFD_ASSERT(a_no_min_word, clk, rst_n, out_valid_reg |-> (frame_reg.accel_x != $signed(ifd_pkg::WORD_MIN)) && (frame_reg.rate_z != $signed(ifd_pkg::WORD_MIN)), "negation not saturated")
    `IFD_ASSERT_ALWAYS(a_done_needs_fire, clk, frame_done |-> byte_fire, "frame completed without an accepted byte")

endmodule

### tb/imu_frame_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the deframer, tracks the framing state on every
// accepted input word and checks each frame word against the predicted one.
module imu_frame_checker
    import ifd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [7:0]         rx_byte,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] accel_x,
    input  logic signed [31:0] accel_y,
    input  logic signed [31:0] accel_z,
    input  logic signed [31:0] rate_x,
    input  logic signed [31:0] rate_y,
    input  logic signed [31:0] rate_z,
    output int                 fail_count,
    output int                 pending
);

    localparam logic [7:0] HDR_SEQ [HDR_BYTES] = '{HDR_BYTE0, HDR_BYTE1, HDR_BYTE2};

    // Shadow framing state
    phase_t             rx_phase;
    logic [CNT_W-1:0]   pos;
    logic               hdr_ok;
    logic [7:0]         frame_bytes [WORD_BYTES];

    frame_t             frames_due [$];
    frame_t             want;
    int                 mism;

    // Little-endian word k of the collected payload, negated with saturation
    function automatic logic signed [31:0] negated_word(input int k);
        logic [31:0] raw;
        raw = {frame_bytes[4*k+3], frame_bytes[4*k+2], frame_bytes[4*k+1], frame_bytes[4*k]};
        if (raw == WORD_MIN)
        begin
            return WORD_MAX;
        end
        return 32'd0 - raw;
    endfunction

    // Advance the shadow state by one accepted byte
    task automatic absorb_byte(input logic [7:0] b);
        int     idx;
        frame_t f;
        case (rx_phase)
            PH_HEADER:
            begin
                idx = (pos > 2) ? 2 : int'(pos);
                if (b != HDR_SEQ[idx])
                begin
                    hdr_ok = 1'b0;
                end
                pos = pos + 1'b1;
                if (pos >= HDR_BYTES)
                begin
                    // a sync byte inside the header does not restart it
                    rx_phase = hdr_ok ? PH_PAYLOAD : PH_HUNT;
                    pos      = '0;
                    hdr_ok   = 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                // trailing bytes past the six words are dropped
                if (pos < WORD_BYTES)
                begin
                    frame_bytes[pos] = b;
                end
                pos = pos + 1'b1;
                if (pos >= PAYLOAD_BYTES)
                begin
                    f.accel_x = negated_word(0);
                    f.accel_y = negated_word(1);
                    f.accel_z = negated_word(2);
                    f.rate_x  = negated_word(3);
                    f.rate_y  = negated_word(4);
                    f.rate_z  = negated_word(5);
                    frames_due.push_back(f);
                    rx_phase = PH_HUNT;
                    pos      = '0;
                    hdr_ok   = 1'b1;
                end
            end
            default:
            begin
                if (b == SYNC_BYTE)
                begin
                    rx_phase = PH_HEADER;
                    pos      = '0;
                    hdr_ok   = 1'b1;
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic signed [31:0] exp_v,
                               input logic signed [31:0] got_v);
        if (got_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            mism++;
        end
    endtask

    // Output side first, then the input word of the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_phase = PH_HUNT;
            pos      = '0;
            hdr_ok   = 1'b1;
            frames_due.delete();
            mism     = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (frames_due.size() == 0)
                begin
                    $error("frame word with no frame expected");
                    mism++;
                end
                else
                begin
                    want = frames_due.pop_front();
                    check_field("accel_x", want.accel_x, accel_x);
                    check_field("accel_y", want.accel_y, accel_y);
                    check_field("accel_z", want.accel_z, accel_z);
                    check_field("rate_x",  want.rate_x,  rate_x);
                    check_field("rate_y",  want.rate_y,  rate_y);
                    check_field("rate_z",  want.rate_z,  rate_z);
                end
            end
            if (in_valid && in_ready)
            begin
                absorb_byte(rx_byte);
            end
            fail_count <= mism;
            pending    <= frames_due.size();
        end
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import ifd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 1700;
    localparam int HOLD_CYCLES  = 400;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [7:0]         rx_byte   = 8'h00;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic signed [31:0] rate_x;
    logic signed [31:0] rate_y;
    logic signed [31:0] rate_z;

    int                 fail_count;
    int                 pending;
    int                 cycle_count = 0;
    int                 framed_bytes = 0;
    int                 rx_hold_len = 0;
    logic               tx_burst = 1'b0;
    logic               rx_burst = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    imu_frame_deframer_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .accel_x   (accel_x),
        .accel_y   (accel_y),
        .accel_z   (accel_z),
        .rate_x    (rate_x),
        .rate_y    (rate_y),
        .rate_z    (rate_z)
    );

    imu_frame_checker frame_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .accel_x    (accel_x),
        .accel_y    (accel_y),
        .accel_z    (accel_z),
        .rate_x     (rate_x),
        .rate_y     (rate_y),
        .rate_z     (rate_z),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random stall per frame word, long hold when asked
    initial
    begin : receiver
        int stall;
        forever
        begin
            @(negedge clk);
            if (rx_hold_len > 0)
            begin
                stall       = rx_hold_len;
                rx_hold_len = 0;
            end
            else
            begin
                stall = rx_burst ? 0 : $urandom_range(0, 5);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // One input word; returns right after the accepting edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 5);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_frame(input logic [NUM_WORDS-1:0][31:0] words,
                              input logic [3:0][7:0] trailer);
        send_byte(SYNC_BYTE);
        send_byte(HDR_BYTE0);
        send_byte(HDR_BYTE1);
        send_byte(HDR_BYTE2);
        for (int k = 0; k < WORD_BYTES; k++)
        begin
            send_byte(words[k / 4][8 * (k % 4) +: 8]);
        end
        for (int k = 0; k < PAYLOAD_BYTES - WORD_BYTES; k++)
        begin
            send_byte(trailer[k]);
        end
        framed_bytes += HDR_BYTES + 1 + PAYLOAD_BYTES;
    endtask

    // Mostly random words, sometimes the edge values
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return WORD_MIN + 1;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_frame();
        logic [NUM_WORDS-1:0][31:0] w;
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            w[i] = pick_word();
        end
        send_frame(w, $urandom);
    endtask

    // Sync byte followed by a header with at least one bad byte
    task automatic send_broken_header();
        int         bad;
        logic [7:0] good;
        logic [7:0] b;
        bad = $urandom_range(0, 2);
        send_byte(SYNC_BYTE);
        for (int i = 0; i < HDR_BYTES; i++)
        begin
            good = (i == 0) ? HDR_BYTE0 : (i == 1) ? HDR_BYTE1 : HDR_BYTE2;
            b    = good;
            if (i == bad || $urandom_range(0, 3) == 0)
            begin
                b = ($urandom_range(0, 3) == 0) ? SYNC_BYTE
                                                : good ^ 8'($urandom_range(1, 255));
            end
            send_byte(b);
        end
        framed_bytes += HDR_BYTES + 1;
    endtask

    // Random bytes, then zeros so any header they opened is closed again
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) send_byte($urandom);
        repeat (HDR_BYTES) send_byte(8'h00);
    endtask

    // Sender pauses until every frame word is out
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int pick;
        int seq_count;
        bit hold_done;
        seq_count = 0;
        hold_done = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: idle bytes, sync inside a header, bad last header byte,
        // then a frame of edge values with a header-like trailer
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(SYNC_BYTE);
        send_byte(SYNC_BYTE);
        send_byte(HDR_BYTE0);
        send_byte(HDR_BYTE1);
        send_byte(HDR_BYTE2);
        send_byte(SYNC_BYTE);
        send_byte(HDR_BYTE0);
        send_byte(HDR_BYTE1);
        send_byte(HDR_BYTE2 ^ 8'h01);
        send_frame({32'h8000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000,
                    WORD_MAX, WORD_MIN},
                   {HDR_BYTE2, HDR_BYTE1, HDR_BYTE0, SYNC_BYTE});
        drain();

        framed_bytes = 0;
        while (framed_bytes < RANDOM_ITEMS)
        begin
            if (seq_count % 8 == 0)
            begin
                tx_burst = ($urandom_range(0, 3) == 0);
                rx_burst = ($urandom_range(0, 3) == 0);
            end

            // Receiver holds off while frames keep coming in
            if (!hold_done && framed_bytes >= RANDOM_ITEMS / 2)
            begin
                hold_done   = 1'b1;
                rx_hold_len = HOLD_CYCLES;
                tx_burst    = 1'b1;
                repeat (5) random_frame();
                tx_burst    = 1'b0;
                drain();
            end

            pick = $urandom_range(0, 19);
            if (pick < 14)
            begin
                random_frame();
            end
            else if (pick < 17)
            begin
                send_broken_header();
            end
            else
            begin
                send_noise();
            end
            seq_count++;
        end

        drain();
        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
